// ===== design/wmr_pkg.sv =====
// Shared types for the white matte removal pipeline.
// No dependencies; imported by wmr_div_stage and white_matte_removal_top.
`timescale 1ns / 1ps

package wmr_pkg;

   localparam int ChanCount = 3;
   localparam int ChanWidth = 8;
   localparam int NumWidth  = 16;
   localparam int DvsWidth  = 15;
   localparam int FullScale = 255;
   // Two quotient bits per divide stage
   localparam int DivStages = ChanWidth / 2;

   // One pixel in flight through the divide stages
   typedef struct packed {
      logic [ChanCount-1:0][NumWidth-1:0]  rem;
      logic [ChanCount-1:0][ChanWidth-1:0] quo;
      logic [DvsWidth-1:0]                 dvs;
      logic [ChanWidth-1:0]                alpha;
      logic [ChanCount-1:0][ChanWidth-1:0] color;
   } pix_type;

endpackage

// ===== design/white_matte_removal_top.sv =====
// Top level of the white matte removal block: prep stage, four divide stages, output stage.
// Depends on wmr_pkg and wmr_div_stage.
//
//   channel  | direction | handshake              | payload
//   req      | in        | req_tvalid/req_tready  | req_tdata  32 bits, one RGBA pixel
//   rsp      | out       | rsp_tvalid/rsp_tready  | rsp_tdata  32 bits, one RGBA pixel
//   csr      | in        | csr_valid/csr_ready    | csr_data   1 bit, black_when_clear
//
// One item per clock sustained while rsp is not stalled; each item passes through the six
// registers in its path (prep stage, four divide stages of two quotient bits each, output
// register), the first of which loads at the accepting edge.
// Reset clears all valid bits and black_when_clear; payload registers are not reset.
// A stall on rsp holds each full stage whose later stages are all full; empty stages still
// fill, so nothing is lost or repeated. csr writes are always accepted.
`timescale 1ns / 1ps

module white_matte_removal_top
   import wmr_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   // red_in[7:0], green_in[15:8], blue_in[23:16], alpha_in[31:24]
   input  logic [31:0] req_tdata,
   input  logic        req_tvalid,
   output logic        req_tready,
   // red_out[7:0], green_out[15:8], blue_out[23:16], alpha_out[31:24]
   output logic [31:0] rsp_tdata,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   input  logic        csr_data,
   input  logic        csr_valid,
   output logic        csr_ready
);

   logic                black_ff;
   logic                prep_valid_ff;
   pix_type             prep_ff;
   pix_type             prep_in;
   logic                prep_ready;
   logic [DivStages:0]  div_valid;
   logic [DivStages:0]  div_ready;
   pix_type             div_data [DivStages+1];
   logic                out_valid_ff;
   logic [31:0]         out_ff;
   logic [31:0]         out_in;
   logic                out_ready;

   // Configuration register
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         black_ff <= 1'b0;
      end else if (csr_valid) begin
         black_ff <= csr_data;
      end
   end

   // Prep: numerator (c + a - 255) * 255, clamped at zero, and divisor a << 7
   always_comb begin
      logic [ChanWidth:0]   sum;
      logic [ChanWidth-1:0] n;
      prep_in.alpha = req_tdata[31:24];
      prep_in.dvs   = {req_tdata[31:24], 7'b0};
      for (int i = 0; i < ChanCount; i++) begin
         prep_in.color[i] = req_tdata[i*ChanWidth +: ChanWidth];
         sum = {1'b0, req_tdata[i*ChanWidth +: ChanWidth]} + {1'b0, req_tdata[31:24]};
         if (sum > (ChanWidth+1)'(FullScale)) begin
            n = ChanWidth'(sum - (ChanWidth+1)'(FullScale));
         end else begin
            n = '0;
         end
         prep_in.rem[i] = {n, 8'b0} - {8'b0, n};
         prep_in.quo[i] = '0;
      end
   end

   assign prep_ready = !prep_valid_ff || div_ready[0];
   assign req_tready = prep_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         prep_valid_ff <= 1'b0;
      end else if (prep_ready) begin
         prep_valid_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (prep_ready && req_tvalid) begin
         prep_ff <= prep_in;
      end
   end

   assign div_valid[0] = prep_valid_ff;
   assign div_data[0]  = prep_ff;

   // Divide stages
   for (genvar s = 0; s < DivStages; s++) begin : g_div
      wmr_div_stage u_stage (
         .clock     (clock),
         .reset     (reset),
         .in_valid  (div_valid[s]),
         .in_ready  (div_ready[s]),
         .in_data   (div_data[s]),
         .out_valid (div_valid[s+1]),
         .out_ready (div_ready[s+1]),
         .out_data  (div_data[s+1])
      );
   end

   assign div_ready[DivStages] = out_ready;

   // Output select: quotient, or the transparent-pixel rule
   always_comb begin
      pix_type p;
      p = div_data[DivStages];
      out_in[31:24] = p.alpha;
      for (int i = 0; i < ChanCount; i++) begin
         if (p.alpha != '0) begin
            out_in[i*ChanWidth +: ChanWidth] = p.quo[i];
         end else if (black_ff) begin
            out_in[i*ChanWidth +: ChanWidth] = '0;
         end else begin
            out_in[i*ChanWidth +: ChanWidth] = p.color[i];
         end
      end
   end

   assign out_ready = !out_valid_ff || rsp_tready;

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (out_ready) begin
         out_valid_ff <= div_valid[DivStages];
      end
   end

   always_ff @(posedge clock) begin
      if (out_ready && div_valid[DivStages]) begin
         out_ff <= out_in;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_ff;

   // Divisor is shifted down to alpha / 2 after the last divide stage
   a_dvs_done: assert property (@(posedge clock) disable iff (reset)
      div_valid[DivStages] |->
         div_data[DivStages].dvs == {8'b0, div_data[DivStages].alpha[7:1]})
      else $error("divisor not fully shifted after last divide stage");

   // Final remainders stay below alpha
   a_rem_small: assert property (@(posedge clock) disable iff (reset)
      (div_valid[DivStages] && div_data[DivStages].alpha != '0) |->
         (div_data[DivStages].rem[0] < {8'b0, div_data[DivStages].alpha}) &&
         (div_data[DivStages].rem[1] < {8'b0, div_data[DivStages].alpha}) &&
         (div_data[DivStages].rem[2] < {8'b0, div_data[DivStages].alpha}))
      else $error("divide remainder not below alpha");

   // Input backpressure only comes from a stalled, full output
   a_ready_cause: assert property (@(posedge clock) disable iff (reset)
      !req_tready |-> (rsp_tvalid && !rsp_tready))
      else $error("req_tready low without output stall");

   // A stalled output item holds its value
   a_out_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tready) |=> $stable(rsp_tdata))
      else $error("output item changed under stall");

endmodule

// ===== design/wmr_div_stage.sv =====
// One registered restoring-divide stage: two quotient bits per channel.
// Depends on wmr_pkg for pix_type.
`timescale 1ns / 1ps

module wmr_div_stage
   import wmr_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    in_valid,
   output logic    in_ready,
   input  pix_type in_data,
   output logic    out_valid,
   input  logic    out_ready,
   output pix_type out_data
);

   logic    valid_ff;
   pix_type data_ff;
   pix_type data_in;

   // Take a new item when empty or when the item held moves on
   assign in_ready = !valid_ff || out_ready;

   // Two compare-and-subtract steps against the shifted divisor
   always_comb begin
      logic [NumWidth-1:0] d_hi;
      logic [NumWidth-1:0] d_lo;
      logic [NumWidth-1:0] r;
      logic                b_hi;
      logic                b_lo;
      d_hi    = {1'b0, in_data.dvs};
      d_lo    = {2'b00, in_data.dvs[DvsWidth-1:1]};
      data_in = in_data;
      for (int i = 0; i < ChanCount; i++) begin
         r    = in_data.rem[i];
         b_hi = (r >= d_hi);
         if (b_hi) begin
            r = r - d_hi;
         end
         b_lo = (r >= d_lo);
         if (b_lo) begin
            r = r - d_lo;
         end
         data_in.rem[i] = r;
         data_in.quo[i] = {in_data.quo[i][ChanWidth-3:0], b_hi, b_lo};
      end
      data_in.dvs = {2'b00, in_data.dvs[DvsWidth-1:2]};
   end

   // Advance valid bit; hold on stall
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
   end

   // Load payload when the stage advances
   always_ff @(posedge clock) begin
      if (in_ready && in_valid) begin
         data_ff <= data_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_data  = data_ff;

endmodule

// ===== tb/testbench.sv =====
// Self-checking bench for white_matte_removal_top: drives RGBA pixels, predicts the
// dematted result of each accepted pixel and checks rsp items in order against it.
// Depends on wmr_pkg and white_matte_removal_top.
`timescale 1ns / 1ps

module testbench;

   localparam int PhaseItems  = 450;
   localparam int SettleDelay = 12;
   localparam int IdleLimit   = 2000;

   // Pixel in the tdata layout: red lowest, alpha highest
   typedef struct packed {
      logic [7:0] alpha;
      logic [7:0] blue;
      logic [7:0] green;
      logic [7:0] red;
   } rgba_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   // red_in[7:0], green_in[15:8], blue_in[23:16], alpha_in[31:24]
   logic [31:0] req_tdata  = '0;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   // red_out[7:0], green_out[15:8], blue_out[23:16], alpha_out[31:24]
   logic [31:0] rsp_tdata;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic        csr_data   = 1'b0;
   logic        csr_valid  = 1'b0;
   logic        csr_ready;

   rgba_type pending_pixels[$];
   rgba_type dematted_pixels[$];
   bit       black_when_clear_copy;
   int       error_count;
   int       burst_left;
   int       gap_left;
   int       cycle_count;
   int       idle_cycles;

   white_matte_removal_top i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tdata  (req_tdata),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .csr_data   (csr_data),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready)
   );

   always #5 clock = ~clock;

   // Remove the white matte from one colour channel
   function automatic logic [7:0] unmatte(logic [7:0] chan, logic [7:0] alpha, bit black);
      int sum;
      int quot;
      if (alpha == 0) begin
         return black ? 8'd0 : chan;
      end
      sum = int'(chan) + int'(alpha);
      if (sum <= wmr_pkg::FullScale) begin
         return 8'd0;
      end
      quot = ((sum - wmr_pkg::FullScale) * wmr_pkg::FullScale) / int'(alpha);
      if (quot > wmr_pkg::FullScale) begin
         quot = wmr_pkg::FullScale;
      end
      return quot[7:0];
   endfunction

   function automatic rgba_type dematte_pixel(rgba_type px, bit black);
      rgba_type res;
      res.red   = unmatte(px.red, px.alpha, black);
      res.green = unmatte(px.green, px.alpha, black);
      res.blue  = unmatte(px.blue, px.alpha, black);
      res.alpha = px.alpha;
      return res;
   endfunction

   function automatic rgba_type make_pixel(int r, int g, int b, int a);
      rgba_type px;
      px.red   = r[7:0];
      px.green = g[7:0];
      px.blue  = b[7:0];
      px.alpha = a[7:0];
      return px;
   endfunction

   // Colour right around the point where c + a crosses full scale
   function automatic logic [7:0] near_threshold(logic [7:0] alpha);
      int c;
      c = wmr_pkg::FullScale - int'(alpha) + int'($urandom_range(0, 6)) - 3;
      if (c < 0) begin
         c = 0;
      end
      if (c > 255) begin
         c = 255;
      end
      return c[7:0];
   endfunction

   function automatic rgba_type random_pixel();
      rgba_type px;
      int       pick;
      px   = $urandom;
      pick = $urandom_range(0, 9);
      case (pick)
         0: begin
            px.alpha = 8'd0;
         end
         1: begin
            px.alpha = 8'hFF;
         end
         2: begin
            px.alpha = 8'($urandom_range(1, 8));
         end
         3, 4: begin
            px.red   = near_threshold(px.alpha);
            px.green = near_threshold(px.alpha);
            px.blue  = near_threshold(px.alpha);
         end
         default: begin
         end
      endcase
      return px;
   endfunction

   // Write the one control register; only called while the block is drained
   task automatic write_black_when_clear(bit value);
      @(posedge clock);
      csr_data  <= value;
      csr_valid <= 1'b1;
      @(posedge clock);
      while (!csr_ready) begin
         @(posedge clock);
      end
      black_when_clear_copy = value;
      csr_valid <= 1'b0;
   endtask

   // Hold until every queued pixel went in and every result came back
   task automatic wait_drained();
      while (pending_pixels.size() != 0 || req_tvalid || dematted_pixels.size() != 0) begin
         @(posedge clock);
      end
      repeat (SettleDelay) @(posedge clock);
      while (req_tvalid || dematted_pixels.size() != 0) begin
         @(posedge clock);
      end
   endtask

   // Stimulus phases
   initial begin
      bit phase_black[4];
      phase_black = '{1'b1, 1'b0, 1'b1, 1'b0};
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // Directed: extremes, alpha zero, colours below, at and above the matte threshold
      write_black_when_clear(1'b0);
      pending_pixels.push_back(make_pixel(8'h00, 8'hFF, 8'h5A, 8'h00));
      pending_pixels.push_back(make_pixel(8'hA5, 8'h01, 8'h80, 8'h00));
      pending_pixels.push_back(make_pixel(8'h00, 8'hFF, 8'h80, 8'hFF));
      pending_pixels.push_back(make_pixel(8'h01, 8'hFE, 8'h7F, 8'hFF));
      pending_pixels.push_back(make_pixel(8'hFE, 8'hFF, 8'h00, 8'h01));
      pending_pixels.push_back(make_pixel(8'h7F, 8'h80, 8'hC8, 8'h80));
      pending_pixels.push_back(make_pixel(8'hFD, 8'hFE, 8'hFF, 8'h02));
      pending_pixels.push_back(make_pixel(8'h7E, 8'h7F, 8'hFF, 8'h81));
      pending_pixels.push_back(make_pixel(8'hFF, 8'hFF, 8'hFF, 8'h55));
      pending_pixels.push_back(make_pixel(8'hAA, 8'hAB, 8'h00, 8'h55));
      pending_pixels.push_back(make_pixel(8'hF5, 8'hF6, 8'hF7, 8'h0A));
      pending_pixels.push_back(make_pixel(8'h00, 8'h00, 8'h00, 8'h00));
      pending_pixels.push_back(make_pixel(8'hFF, 8'hFF, 8'hFF, 8'h00));
      wait_drained();

      write_black_when_clear(1'b1);
      pending_pixels.push_back(make_pixel(8'h00, 8'hFF, 8'h5A, 8'h00));
      pending_pixels.push_back(make_pixel(8'hA5, 8'h01, 8'h80, 8'h00));
      pending_pixels.push_back(make_pixel(8'hFF, 8'hFF, 8'hFF, 8'h00));
      pending_pixels.push_back(make_pixel(8'hFF, 8'h00, 8'h80, 8'h01));
      wait_drained();

      // Random phases, each ending with the sender held until the block drains
      foreach (phase_black[p]) begin
         write_black_when_clear(phase_black[p]);
         repeat (PhaseItems) pending_pixels.push_back(random_pixel());
         wait_drained();
      end

      if (error_count == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

   // Driver: present queued pixels in bursts with random gaps
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
         burst_left = $urandom_range(1, 20);
         gap_left   = 0;
      end else begin
         if (req_tvalid && req_tready) begin
            dematted_pixels.push_back(dematte_pixel(rgba_type'(req_tdata),
                                                    black_when_clear_copy));
         end
         if (!req_tvalid || req_tready) begin
            if (gap_left > 0) begin
               gap_left--;
               req_tvalid <= 1'b0;
            end else if (pending_pixels.size() != 0) begin
               req_tdata  <= pending_pixels.pop_front();
               req_tvalid <= 1'b1;
               burst_left--;
               if (burst_left <= 0) begin
                  burst_left = $urandom_range(1, 40);
                  gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 7);
               end
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // Monitor: stall rsp on a rotating pattern and check each result item
   always @(posedge clock) begin
      rgba_type want;
      rgba_type got;
      cycle_count++;
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         case ((cycle_count / 97) % 4)
            0: rsp_tready <= 1'b1;
            1: rsp_tready <= 1'($urandom_range(0, 1));
            2: rsp_tready <= (cycle_count % 7) >= 3;
            default: rsp_tready <= $urandom_range(0, 6) != 0;
         endcase
         if (rsp_tvalid && rsp_tready) begin
            got = rgba_type'(rsp_tdata);
            if (dematted_pixels.size() == 0) begin
               $display("%0t: unexpected item, expected none, actual %h", $time, rsp_tdata);
               error_count++;
            end else begin
               want = dematted_pixels.pop_front();
               if (got.red !== want.red) begin
                  $display("%0t: red_out expected %h actual %h", $time, want.red, got.red);
                  error_count++;
               end
               if (got.green !== want.green) begin
                  $display("%0t: green_out expected %h actual %h", $time, want.green,
                           got.green);
                  error_count++;
               end
               if (got.blue !== want.blue) begin
                  $display("%0t: blue_out expected %h actual %h", $time, want.blue, got.blue);
                  error_count++;
               end
               if (got.alpha !== want.alpha) begin
                  $display("%0t: alpha_out expected %h actual %h", $time, want.alpha,
                           got.alpha);
                  error_count++;
               end
            end
         end
      end
   end

   // Watchdog: end the run when nothing moves on any channel for too long
   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) ||
          (csr_valid && csr_ready)) begin
         idle_cycles = 0;
      end else begin
         idle_cycles++;
      end
      if (idle_cycles >= IdleLimit) begin
         $display("%0t: timeout, expected %0d more items, actual none", $time,
                  dematted_pixels.size());
         $display("DONE: errors detected");
         $finish;
      end
   end

endmodule

// ===== files.f =====
design/wmr_pkg.sv
design/wmr_div_stage.sv
design/white_matte_removal_top.sv
tb/testbench.sv
